// File: hw/rtl/oal_pkg.sv
// ordered array list: shared types and codes
// used by oal_cell and ordered_array_list_unit
package oal_pkg;

  localparam int WordW  = 32;
  localparam int FieldW = 6;

  // operation codes of an input item
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_READ   = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [WordW-1:0] value;
  } cell_cmd_t;

endpackage

// File: hw/rtl/oal_cell.sv
// ordered array list: one storage cell of the shifting chain
// depends on oal_pkg (cell_cmd_t)
module oal_cell #(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  logic                     clk,
  input  oal_pkg::cell_cmd_t       cmd_i,
  input  logic [PW-1:0]            pos_i,
  input  logic [PW-1:0]            cnt_i,
  input  logic signed [31:0]       left_i,
  input  logic signed [31:0]       right_i,
  output logic signed [31:0]       entry_o,
  output logic                     match_o,
  output logic signed [31:0]       rd_o
);
  import oal_pkg::*;

  // one-based position of this cell
  localparam logic [PW-1:0] SLOT_POS = PW'(IDX + 1);

  logic signed [WordW-1:0] entry_r, entry_nxt;

  // insert writes here or shifts up from the left, delete shifts down from the right
  always_comb begin
    priority if (cmd_i.ins && (SLOT_POS == pos_i)) begin
      entry_nxt = cmd_i.value;
    end else if (cmd_i.ins && (SLOT_POS > pos_i)) begin
      entry_nxt = left_i;
    end else if (cmd_i.del && (SLOT_POS >= pos_i)) begin
      entry_nxt = right_i;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // compare and read taps, only live entries may match
  assign entry_o = entry_r;
  assign match_o = (entry_r == cmd_i.value) && (SLOT_POS <= cnt_i);
  assign rd_o    = (SLOT_POS == pos_i) ? entry_r : '0;

endmodule

// File: hw/rtl/oal_find.sv
// ordered array list: first-match encoder for locate
// no package dependency
module oal_find #(
  parameter int N  = 32,
  parameter int CW = 6
) (
  input  logic [N-1:0]  match_i,
  output logic [CW-1:0] found_o
);

  logic [N-1:0] first;

  // isolate the lowest set bit
  assign first = match_i & (~match_i + N'(1));

  // encode one-hot to a one-based position, zero when nothing matched
  always_comb begin
    found_o = '0;
    for (int i = 0; i < N; i++) begin
      if (first[i]) begin
        found_o = found_o | CW'(i + 1);
      end
    end
  end

endmodule

// File: hw/rtl/ordered_array_list_unit.sv
// ordered array list: top level with the cell chain, result stage and output register
// depends on oal_pkg, oal_cell and oal_find
//
// Usage:
//   Input channel in_valid/in_stall carries op, pos and value; the result channel
//   out_valid/out_stall returns status, read_value, found_pos and count, one result
//   per input transfer, in order.
//   The list lives in a chain of MAX_ENTRIES cells. At the input transfer every cell
//   shifts, loads or holds in one step and compares its word against value.
//   The result stage turns the registered compare vector into the first matching
//   position; the result then sits in the output register.
//   Throughput: one item per cycle while the receiver takes results; the chain
//   update plus the result stage sets that figure.
//   When the receiver stalls, the output register holds its result, the result
//   stage holds one more item, and then in_stall rises until the result moves.
//   Reset (rst_n low, synchronous) empties the list and drops any pending results;
//   cell contents are left as they are and are never read before being written.
module ordered_array_list_unit #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic [5:0]         in_pos,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_read_value,
  output logic [5:0]         out_found_pos,
  output logic [5:0]         out_count
);
  import oal_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = ((CW > FieldW) ? CW : FieldW) + 1;
  localparam logic [PW-1:0] MAX_W = PW'(MAX_ENTRIES);

  logic                     in_acc;
  logic                     advance;
  logic [PW-1:0]            pos_w;
  logic [PW-1:0]            cnt_w;
  logic                     bad_rd;
  logic                     bad_ins;
  cell_cmd_t                cmd;
  logic                     do_read;
  status_t                  status_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;

  logic signed [WordW-1:0]  entry   [MAX_ENTRIES];
  logic signed [WordW-1:0]  rd_tap  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]   match;
  logic signed [WordW-1:0]  rd_any;

  // result stage
  logic                     busy_r;
  op_t                      op_r;
  status_t                  status_r;
  logic signed [WordW-1:0]  rd_r;
  logic [MAX_ENTRIES-1:0]   match_r;
  logic [FieldW-1:0]        cnt_r;
  logic [CW-1:0]            found;

  // output register
  logic                     out_valid_r;
  status_t                  out_status_r;
  logic signed [WordW-1:0]  out_rd_r;
  logic [FieldW-1:0]        out_found_r;
  logic [FieldW-1:0]        out_cnt_r;

  // handshake
  assign advance  = busy_r && (!out_valid_r || !out_stall);
  assign in_stall = busy_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  assign pos_w   = PW'(in_pos);
  assign cnt_w   = PW'(fill_r);
  assign bad_rd  = (pos_w == '0) || (pos_w > cnt_w);
  assign bad_ins = (pos_w == '0) || (pos_w > (cnt_w + PW'(1)));

  // decode the operation against the current count
  always_comb begin
    cmd.ins    = 1'b0;
    cmd.del    = 1'b0;
    cmd.value  = in_value;
    do_read    = 1'b0;
    status_nxt = ST_OK;
    fill_nxt   = fill_r;
    unique case (op_t'(in_op))
      OP_INSERT: begin
        if (bad_ins) begin
          status_nxt = ST_BADPOS;
        end else if (cnt_w == MAX_W) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins  = in_acc;
          fill_nxt = CW'(cnt_w + PW'(1));
        end
      end
      OP_DELETE: begin
        if (bad_rd) begin
          status_nxt = ST_BADPOS;
        end else begin
          cmd.del  = in_acc;
          fill_nxt = CW'(cnt_w - PW'(1));
        end
      end
      OP_READ: begin
        if (bad_rd) begin
          status_nxt = ST_BADPOS;
        end else begin
          do_read = 1'b1;
        end
      end
      OP_LOCATE: begin
        status_nxt = ST_NOTFOUND;
      end
      OP_CLEAR: begin
        fill_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // chain of cells, each linked to its neighbors
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic signed [WordW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = entry[g];
    end else begin : g_inner_l
      assign left_w = entry[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign right_w = entry[g];
    end else begin : g_inner_r
      assign right_w = entry[g+1];
    end
    oal_cell #(
      .IDX (g),
      .PW  (PW)
    ) u_cell (
      .clk     (clk),
      .cmd_i   (cmd),
      .pos_i   (pos_w),
      .cnt_i   (cnt_w),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry[g]),
      .match_o (match[g]),
      .rd_o    (rd_tap[g])
    );
  end

  // merge read taps, at most one is nonzero
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rd_any = rd_any | rd_tap[i];
    end
  end

  // list count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (in_acc) begin
      fill_r <= fill_nxt;
    end
  end

  // result stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
    end else if (advance) begin
      busy_r <= 1'b0;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= op_t'(in_op);
      status_r <= status_nxt;
      rd_r     <= do_read ? rd_any : '0;
      match_r  <= match;
      cnt_r    <= FieldW'(fill_nxt);
    end
  end

  oal_find #(
    .N  (MAX_ENTRIES),
    .CW (CW)
  ) u_find (
    .match_i (match_r),
    .found_o (found)
  );

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_rd_r  <= rd_r;
      out_cnt_r <= cnt_r;
      if (op_r == OP_LOCATE) begin
        out_status_r <= (found != '0) ? ST_OK : ST_NOTFOUND;
        out_found_r  <= FieldW'(found);
      end else begin
        out_status_r <= status_r;
        out_found_r  <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_rd_r;
  assign out_found_pos  = out_found_r;
  assign out_count      = out_cnt_r;

`ifndef ASSERT_OFF
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_w <= MAX_W)
    else $error("list count above capacity");

  a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> (fill_r == $past(fill_r) + CW'(1)))
    else $error("insert did not grow the list by one");

  a_stage_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r)
    else $error("accepted item missing from result stage");

  a_miss_no_pos : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NOTFOUND)) |-> (out_found_pos == '0))
    else $error("locate miss reports a position");
`endif

endmodule
